### rtl/hbkrd_pkg.sv
// ----------------------------------------------------------------------------
// hbkrd_pkg
// Shared types, constants and the usage-to-keycode table of the boot
// keyboard report decoder.
// ----------------------------------------------------------------------------
package hbkrd_pkg;

	localparam int KEY_SLOTS    = 6;
	localparam int MOD_BASE     = 224;
	localparam int MOD_COUNT    = 8;
	localparam int RESERVED_MAX = 3;

	// one sequencer step per modifier, then release and press per slot
	localparam int EVT_STEPS = MOD_COUNT + 2 * KEY_SLOTS;
	localparam int STEP_W    = $clog2(EVT_STEPS);
	localparam int CODE_N    = 2 * KEY_SLOTS;
	localparam int CODE_W    = $clog2(CODE_N);
	localparam int MOD_W     = $clog2(MOD_COUNT);

	typedef struct packed {
		logic       report_ok;
		logic [7:0] modifier_bits;
		logic [7:0] key_slot_0;
		logic [7:0] key_slot_1;
		logic [7:0] key_slot_2;
		logic [7:0] key_slot_3;
		logic [7:0] key_slot_4;
		logic [7:0] key_slot_5;
	} report_t;

	typedef struct packed {
		logic [7:0] key_code;
		logic [7:0] scan_code;
		logic       pressed;
		logic       unknown;
		logic       last;
	} key_evt_t;

	// classified report: codes are interleaved old/new per slot, fire marks
	// which of those steps produce an event
	typedef struct packed {
		logic [MOD_COUNT-1:0]         mods;
		logic [CODE_N-1:0][7:0]       codes;
		logic [CODE_N-1:0]            fire;
	} job_t;

	localparam logic [7:0] USAGE_ROM [256] = '{
		8'd0,   8'd0,   8'd0,   8'd0,   8'd30,  8'd48,  8'd46,  8'd32,
		8'd18,  8'd33,  8'd34,  8'd35,  8'd23,  8'd36,  8'd37,  8'd38,
		8'd50,  8'd49,  8'd24,  8'd25,  8'd16,  8'd19,  8'd31,  8'd20,
		8'd22,  8'd47,  8'd17,  8'd45,  8'd21,  8'd44,  8'd2,   8'd3,
		8'd4,   8'd5,   8'd6,   8'd7,   8'd8,   8'd9,   8'd10,  8'd11,
		8'd28,  8'd1,   8'd14,  8'd15,  8'd57,  8'd12,  8'd13,  8'd26,
		8'd27,  8'd43,  8'd43,  8'd39,  8'd40,  8'd41,  8'd51,  8'd52,
		8'd53,  8'd58,  8'd59,  8'd60,  8'd61,  8'd62,  8'd63,  8'd64,
		8'd65,  8'd66,  8'd67,  8'd68,  8'd87,  8'd88,  8'd99,  8'd70,
		8'd119, 8'd110, 8'd102, 8'd104, 8'd111, 8'd107, 8'd109, 8'd106,
		8'd105, 8'd108, 8'd103, 8'd69,  8'd98,  8'd55,  8'd74,  8'd78,
		8'd96,  8'd79,  8'd80,  8'd81,  8'd75,  8'd76,  8'd77,  8'd71,
		8'd72,  8'd73,  8'd82,  8'd83,  8'd86,  8'd127, 8'd116, 8'd117,
		8'd183, 8'd184, 8'd185, 8'd186, 8'd187, 8'd188, 8'd189, 8'd190,
		8'd191, 8'd192, 8'd193, 8'd194, 8'd134, 8'd138, 8'd130, 8'd132,
		8'd128, 8'd129, 8'd131, 8'd137, 8'd133, 8'd135, 8'd136, 8'd113,
		8'd115, 8'd114, 8'd0,   8'd0,   8'd0,   8'd121, 8'd0,   8'd89,
		8'd93,  8'd124, 8'd92,  8'd94,  8'd95,  8'd0,   8'd0,   8'd0,
		8'd122, 8'd123, 8'd90,  8'd91,  8'd85,  8'd0,   8'd0,   8'd0,
		8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
		8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
		8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
		8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
		8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
		8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
		8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
		8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
		8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
		8'd29,  8'd42,  8'd56,  8'd125, 8'd97,  8'd54,  8'd100, 8'd126,
		8'd164, 8'd166, 8'd165, 8'd163, 8'd161, 8'd115, 8'd114, 8'd113,
		8'd150, 8'd158, 8'd159, 8'd128, 8'd136, 8'd177, 8'd178, 8'd176,
		8'd142, 8'd152, 8'd173, 8'd140, 8'd0,   8'd0,   8'd0,   8'd0
	};

endpackage

### rtl/hbkrd_front.sv
// ----------------------------------------------------------------------------
// hbkrd_front
// Accepts reports, compares the new key slots against the held ones and
// hands a classified job to the queue. Owns the previous key state.
// ----------------------------------------------------------------------------
module hbkrd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid,
	output logic               stall,
	input  hbkrd_pkg::report_t rpt,
	input  logic               q_full,
	output logic               push,
	output hbkrd_pkg::job_t    push_job
);

	logic [hbkrd_pkg::KEY_SLOTS-1:0][7:0] prev_q;
	logic [hbkrd_pkg::KEY_SLOTS-1:0][7:0] fresh;
	logic [hbkrd_pkg::KEY_SLOTS-1:0]      rel_hit;
	logic [hbkrd_pkg::KEY_SLOTS-1:0]      prs_hit;
	logic                                 accept;

	assign fresh[0] = rpt.key_slot_0;
	assign fresh[1] = rpt.key_slot_1;
	assign fresh[2] = rpt.key_slot_2;
	assign fresh[3] = rpt.key_slot_3;
	assign fresh[4] = rpt.key_slot_4;
	assign fresh[5] = rpt.key_slot_5;

	assign stall  = q_full;
	assign accept = valid && !stall;
	assign push   = accept && rpt.report_ok;

	// presence matrix: old code seen in new slots, new code seen in old slots
	always_comb begin
		for (int k = 0; k < hbkrd_pkg::KEY_SLOTS; k++) begin
			rel_hit[k] = 1'b0;
			prs_hit[k] = 1'b0;
			for (int m = 0; m < hbkrd_pkg::KEY_SLOTS; m++) begin
				rel_hit[k] = rel_hit[k] | (prev_q[k] == fresh[m]);
				prs_hit[k] = prs_hit[k] | (fresh[k] == prev_q[m]);
			end
		end
	end

	always_comb begin
		push_job.mods = rpt.modifier_bits;
		for (int k = 0; k < hbkrd_pkg::KEY_SLOTS; k++) begin
			push_job.codes[2*k]   = prev_q[k];
			push_job.codes[2*k+1] = fresh[k];
			push_job.fire[2*k]    = (prev_q[k] > 8'(hbkrd_pkg::RESERVED_MAX)) && !rel_hit[k];
			push_job.fire[2*k+1]  = (fresh[k] > 8'(hbkrd_pkg::RESERVED_MAX)) && !prs_hit[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (push) begin
			prev_q <= fresh;
		end
	end

endmodule

### rtl/hbkrd_queue.sv
// ----------------------------------------------------------------------------
// hbkrd_queue
// Two-entry job queue between the classifier and the event sequencer.
// ----------------------------------------------------------------------------
module hbkrd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  hbkrd_pkg::job_t push_job,
	output logic            full,
	output logic            nonempty,
	input  logic            pop,
	output hbkrd_pkg::job_t head
);

	hbkrd_pkg::job_t mem_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;

	assign full     = (count_q == 2'd2);
	assign nonempty = (count_q != 2'd0);
	assign head     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("queue count out of range");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!nonempty |-> !pop)
		else $error("pop from empty queue");
`endif

endmodule

### rtl/hbkrd_back.sv
// ----------------------------------------------------------------------------
// hbkrd_back
// Event sequencer: steps a job once a cycle unless stalled, translates each
// firing step through the keycode table and holds it in the output register.
// ----------------------------------------------------------------------------
module hbkrd_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_nonempty,
	input  hbkrd_pkg::job_t      q_head,
	output logic                 pop,
	output logic                 valid,
	input  logic                 stall,
	output hbkrd_pkg::key_evt_t  evt
);

	localparam logic [hbkrd_pkg::STEP_W-1:0] LAST_STEP =
		hbkrd_pkg::STEP_W'(hbkrd_pkg::EVT_STEPS - 1);

	hbkrd_pkg::job_t                job_q;
	logic                           busy_q;
	logic [hbkrd_pkg::STEP_W-1:0]   step_q;
	logic                           evt_valid_q;
	hbkrd_pkg::key_evt_t            evt_q;

	logic [hbkrd_pkg::EVT_STEPS-1:0] fire_all;
	logic                            fire_cur;
	logic                            later_any;
	logic                            out_free;
	logic                            advance;
	logic                            emit;
	logic                            finish;
	logic                            is_mod;
	logic [hbkrd_pkg::STEP_W-1:0]    key_idx;
	logic [7:0]                      scan;
	logic                            down;
	hbkrd_pkg::key_evt_t             evt_d;

	assign fire_all = {job_q.fire, {hbkrd_pkg::MOD_COUNT{1'b1}}};
	assign fire_cur = fire_all[step_q];

	always_comb begin
		later_any = 1'b0;
		for (int i = 0; i < hbkrd_pkg::EVT_STEPS; i++) begin
			later_any = later_any | (fire_all[i] && (hbkrd_pkg::STEP_W'(i) > step_q));
		end
	end

	assign out_free = !evt_valid_q || !stall;
	assign advance  = busy_q && (!fire_cur || out_free);
	assign emit     = busy_q && fire_cur && out_free;
	assign finish   = advance && (step_q == LAST_STEP);
	assign pop      = q_nonempty && (!busy_q || finish);

	// steps below MOD_COUNT are modifiers, then old/new code per slot
	assign is_mod  = (step_q < hbkrd_pkg::STEP_W'(hbkrd_pkg::MOD_COUNT));
	assign key_idx = step_q - hbkrd_pkg::STEP_W'(hbkrd_pkg::MOD_COUNT);

	always_comb begin
		if (is_mod) begin
			scan = 8'(hbkrd_pkg::MOD_BASE) + {{(8-hbkrd_pkg::MOD_W){1'b0}},
				step_q[hbkrd_pkg::MOD_W-1:0]};
			down = job_q.mods[step_q[hbkrd_pkg::MOD_W-1:0]];
		end else begin
			scan = job_q.codes[key_idx[hbkrd_pkg::CODE_W-1:0]];
			down = key_idx[0];
		end
		evt_d.scan_code = scan;
		evt_d.key_code  = hbkrd_pkg::USAGE_ROM[scan];
		evt_d.unknown   = (hbkrd_pkg::USAGE_ROM[scan] == 8'd0);
		evt_d.pressed   = down;
		evt_d.last      = !later_any;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			step_q      <= '0;
			evt_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (finish) begin
				busy_q <= 1'b0;
			end else if (advance) begin
				step_q <= step_q + hbkrd_pkg::STEP_W'(1);
			end
			if (emit) begin
				evt_valid_q <= 1'b1;
			end else if (!stall) begin
				evt_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= q_head;
		end
		if (emit) begin
			evt_q <= evt_d;
		end
	end

	assign valid = evt_valid_q;
	assign evt   = evt_q;

`ifndef SYNTHESIS
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> step_q <= LAST_STEP)
		else $error("sequencer step out of range");

	a_start_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> busy_q && step_q == '0)
		else $error("job did not start at first step");

	a_mod_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && is_mod) |=> evt_q.scan_code[7:5] == 3'b111)
		else $error("modifier event with wrong scan code");
`endif

endmodule

### rtl/hid_boot_keyboard_report_decoder.sv
// ----------------------------------------------------------------------------
// hid_boot_keyboard_report_decoder
// Turns boot keyboard reports into a stream of key press and release beats.
// ----------------------------------------------------------------------------
// A valid report is accepted while the queue is not full and classified at
// once against the six held key slots; the classified report waits in a
// two-entry queue. The event sequencer then walks its steps, emitting the
// eight modifier beats and then, slot by slot, a release and a press where
// they apply; the last beat of a report carries last. Its step counter
// paces valid reports; reports with report_ok low are accepted likewise and
// emit nothing. Up to two further reports are taken while the sequencer
// works, and a beat waiting on a stalled output holds the input side only
// once the queue is full.
// ----------------------------------------------------------------------------
module hid_boot_keyboard_report_decoder (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rpt_valid,
	output logic                 rpt_stall,
	input  hbkrd_pkg::report_t   rpt,
	output logic                 evt_valid,
	input  logic                 evt_stall,
	output hbkrd_pkg::key_evt_t  evt
);

	logic            q_push;
	logic            q_full;
	logic            q_nonempty;
	logic            q_pop;
	hbkrd_pkg::job_t q_in;
	hbkrd_pkg::job_t q_head;

	hbkrd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid    (rpt_valid),
		.stall    (rpt_stall),
		.rpt      (rpt),
		.q_full   (q_full),
		.push     (q_push),
		.push_job (q_in)
	);

	hbkrd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (q_in),
		.full     (q_full),
		.nonempty (q_nonempty),
		.pop      (q_pop),
		.head     (q_head)
	);

	hbkrd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.q_head     (q_head),
		.pop        (q_pop),
		.valid      (evt_valid),
		.stall      (evt_stall),
		.evt        (evt)
	);

endmodule
